### hdl/gqff_pkg.sv
// Shared types, constants and codes of the game query flood filter.
`timescale 1ns / 1ps
package gqff_pkg;

	localparam int TRACK_SLOTS = 64;
	localparam int BLOCK_SLOTS = 16;
	localparam int TRK_IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
	localparam int BLK_IW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_PROTECT_EN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONN_PROTECT_EN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_BLOCK_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SECONDS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_QUERIES_SEC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_QUERIES_MIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CONNS_SEC    = 3'd6;

	localparam logic [1:0] VERDICT_PASS    = 2'd0;
	localparam logic [1:0] VERDICT_BLOCKED = 2'd1;
	localparam logic [1:0] VERDICT_QFLOOD  = 2'd2;
	localparam logic [1:0] VERDICT_CFLOOD  = 2'd3;

	localparam logic [1:0] CLASS_OTHER = 2'd0;
	localparam logic [1:0] CLASS_QUERY = 2'd1;
	localparam logic [1:0] CLASS_CONN  = 2'd2;
	localparam logic [1:0] CLASS_RCON  = 2'd3;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [15:0] udp_port;
		logic [15:0] payload_len;
		logic [7:0]  hdr_byte0;
		logic [7:0]  hdr_byte1;
		logic [7:0]  hdr_byte2;
		logic [7:0]  hdr_byte3;
		logic [7:0]  hdr_byte4;
		logic [7:0]  hdr_byte5;
		logic [31:0] now_seconds;
	} in_word_t;

	typedef struct packed {
		logic       accept;
		logic [1:0] verdict;
		logic [1:0] pkt_class;
	} out_word_t;

	typedef struct packed {
		logic ld_in;
		logic chk;
		logic tscan;
		logic tupd;
		logic bscan;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic chk_fin;
		logic chk_scan;
		logic tscan_last;
		logic need_bscan;
		logic bscan_last;
	} stat_t;

endpackage

### hdl/gqff_ctrl.sv
// Sequencing state machine of the game query flood filter.
`timescale 1ns / 1ps
module gqff_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  gqff_pkg::stat_t st,
	output gqff_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHK   = 3'd1;
	localparam logic [2:0] ST_TSCAN = 3'd2;
	localparam logic [2:0] ST_TUPD  = 3'd3;
	localparam logic [2:0] ST_BSCAN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_CHK;
				end
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				if (st.chk_fin) state_d = ST_DONE;
				else if (st.chk_scan) state_d = ST_TSCAN;
				else state_d = ST_TUPD;
			end
			ST_TSCAN: begin
				cmd.tscan = 1'b1;
				if (st.tscan_last) state_d = ST_TUPD;
			end
			ST_TUPD: begin
				cmd.tupd = 1'b1;
				state_d  = st.need_bscan ? ST_BSCAN : ST_DONE;
			end
			ST_BSCAN: begin
				cmd.bscan = 1'b1;
				if (st.bscan_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word lost under stall");
	a_ld_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> out_free)
		else $error("result overwritten before taken");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_in |=> state_q == ST_CHK)
		else $error("accepted word not checked");

endmodule

### hdl/gqff_dp.sv
// Datapath of the game query flood filter: tables, tracker memory, decisions.
`timescale 1ns / 1ps
module gqff_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gqff_pkg::in_word_t                  in_data,
	output gqff_pkg::out_word_t                 out_data,
	input  logic                                cfg_we,
	input  logic [gqff_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gqff_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  gqff_pkg::cmd_t                      cmd,
	output gqff_pkg::stat_t                     st
);

	localparam int TS  = gqff_pkg::TRACK_SLOTS;
	localparam int BS  = gqff_pkg::BLOCK_SLOTS;
	localparam int TIW = gqff_pkg::TRK_IW;
	localparam int BIW = gqff_pkg::BLK_IW;

	typedef struct packed {
		logic [31:0] last_seen;
		logic [31:0] win_start;
		logic [31:0] qcount;
		logic [31:0] ccount;
	} rec_t;

	function automatic logic is_game_port(input logic [15:0] p);
		return (p >= 16'd27010 && p <= 16'd27030) || p == 16'd3478 || p == 16'd4379 ||
			p == 16'd4380 || p == 16'd27005 || p == 16'd27006 || p == 16'd27036 ||
			p == 16'd27037;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] x);
		return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
	endfunction

	logic        query_en_q, conn_en_q, auto_en_q;
	logic [31:0] block_sec_q, max_qs_q, max_cs_q;

	gqff_pkg::in_word_t  in_q;
	gqff_pkg::out_word_t res_q;
	gqff_pkg::out_word_t out_q;

	logic [BS-1:0] blk_valid_q;
	logic [31:0]   blk_addr_q  [BS];
	logic [31:0]   blk_start_q [BS];
	logic [31:0]   blk_dur_q   [BS];

	logic [TS-1:0] trk_valid_q;
	logic [31:0]   trk_addr_q [TS];
	logic [15:0]   trk_port_q [TS];
	rec_t          trk_mem    [TS];
	rec_t          rd_q;

	logic [TIW-1:0] idx_q;
	logic           new_q;
	logic           isq_q;
	logic [1:0]     cls_q;
	logic [TIW:0]   cnt_q;
	logic           cmp_v_q;
	logic [TIW-1:0] cmp_i_q;
	logic [31:0]    best_q;
	logic [BIW-1:0] bcnt_q;
	logic [BIW-1:0] bidx_q;

	logic [BS-1:0]  blk_exp, blk_match;
	logic           blk_hit, blk_full;
	logic [BIW-1:0] blk_free;
	logic [TS-1:0]  trk_hit;
	logic           any_hit, trk_full;
	logic [TIW-1:0] hit_idx, free_idx, rd_addr;
	logic           pre, q, c, r, need;
	logic [1:0]     cls;
	rec_t           rec, wrec;
	logic [31:0]    age, tage, bage;
	logic           age1, flood, tbetter, bbetter;
	logic [BIW-1:0] bpick;

	always_comb begin
		blk_hit  = 1'b0;
		blk_free = '0;
		for (int i = 0; i < BS; i++) begin
			blk_exp[i]   = blk_valid_q[i] &&
				((in_q.now_seconds - blk_start_q[i]) > blk_dur_q[i]);
			blk_match[i] = blk_valid_q[i] && !blk_exp[i] && blk_addr_q[i] == in_q.src_addr;
			blk_hit      = blk_hit | blk_match[i];
		end
		for (int i = BS - 1; i >= 0; i--)
			if (!blk_valid_q[i]) blk_free = BIW'(i);
		blk_full = &blk_valid_q;
	end

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < TS; i++)
			trk_hit[i] = trk_valid_q[i] && trk_addr_q[i] == in_q.src_addr &&
				trk_port_q[i] == in_q.udp_port;
		for (int i = TS - 1; i >= 0; i--) begin
			if (trk_hit[i]) hit_idx = TIW'(i);
			if (!trk_valid_q[i]) free_idx = TIW'(i);
		end
		any_hit  = |trk_hit;
		trk_full = &trk_valid_q;
	end

	always_comb begin
		pre = in_q.payload_len >= 16'd5 && in_q.hdr_byte0 == 8'hFF &&
			in_q.hdr_byte1 == 8'hFF && in_q.hdr_byte2 == 8'hFF && in_q.hdr_byte3 == 8'hFF;
		q = pre && (in_q.hdr_byte4 inside {8'h49, 8'h54, 8'h55, 8'h56, 8'h41});
		c = pre && (in_q.hdr_byte4 == 8'h09 || in_q.hdr_byte4 == 8'h0C ||
			(in_q.payload_len >= 16'd6 && in_q.hdr_byte4 == 8'h01 && in_q.hdr_byte5 == 8'h00));
		r = pre && in_q.payload_len >= 16'd12 && in_q.hdr_byte4 == 8'h63;
		if (!q && !c && !r && in_q.payload_len != 16'd0 && in_q.hdr_byte0 == 8'hFF) q = 1'b1;
		cls  = q ? gqff_pkg::CLASS_QUERY : c ? gqff_pkg::CLASS_CONN :
			r ? gqff_pkg::CLASS_RCON : gqff_pkg::CLASS_OTHER;
		need = (q && query_en_q) || (c && conn_en_q);
	end

	always_comb begin
		rec   = new_q ? rec_t'{in_q.now_seconds, in_q.now_seconds, 32'd0, 32'd0} : rd_q;
		age   = in_q.now_seconds - rec.win_start;
		age1  = (age != 32'd0);
		flood = age1 && (isq_q ? (rec.qcount > max_qs_q) : (rec.ccount > max_cs_q));
		wrec.last_seen = in_q.now_seconds;
		wrec.win_start = age1 ? in_q.now_seconds : rec.win_start;
		wrec.qcount    = rec.qcount;
		wrec.ccount    = rec.ccount;
		if (isq_q) wrec.qcount = age1 ? 32'd1 : sat_inc(rec.qcount);
		else wrec.ccount = age1 ? 32'd1 : sat_inc(rec.ccount);
		tage    = in_q.now_seconds - rd_q.last_seen;
		tbetter = (cmp_i_q == '0) || (tage > best_q);
		bage    = in_q.now_seconds - blk_start_q[bcnt_q];
		bbetter = (bcnt_q == '0) || (bage > best_q);
		bpick   = bbetter ? bcnt_q : bidx_q;
		rd_addr = cmd.chk ? hit_idx : cnt_q[TIW-1:0];
	end

	assign st.chk_fin    = blk_hit || !is_game_port(in_q.udp_port) || !need;
	assign st.chk_scan   = need && !any_hit && trk_full;
	assign st.tscan_last = cmp_v_q && cmp_i_q == TIW'(TS - 1);
	assign st.need_bscan = flood && auto_en_q && blk_full;
	assign st.bscan_last = (bcnt_q == BIW'(BS - 1));
	assign out_data      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_en_q  <= 1'b1;
			conn_en_q   <= 1'b1;
			auto_en_q   <= 1'b1;
			block_sec_q <= 32'd300;
			max_qs_q    <= 32'd100;
			max_cs_q    <= 32'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				gqff_pkg::REG_QUERY_PROTECT_EN: query_en_q <= cfg_data[0];
				gqff_pkg::REG_CONN_PROTECT_EN:  conn_en_q  <= cfg_data[0];
				gqff_pkg::REG_AUTO_BLOCK_EN:    auto_en_q  <= cfg_data[0];
				gqff_pkg::REG_BLOCK_SECONDS:    block_sec_q <= cfg_data;
				gqff_pkg::REG_MAX_QUERIES_SEC:  max_qs_q   <= cfg_data;
				// per-minute limit sees a cleared count and never trips: drop it
				gqff_pkg::REG_MAX_QUERIES_MIN:  ;
				gqff_pkg::REG_MAX_CONNS_SEC:    max_cs_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_q <= '0;
			trk_valid_q <= '0;
		end else begin
			if (cmd.chk) blk_valid_q <= blk_valid_q & ~blk_exp;
			if (cmd.tupd && flood && auto_en_q && !blk_full) blk_valid_q[blk_free] <= 1'b1;
			if (cmd.bscan && st.bscan_last) blk_valid_q[bpick] <= 1'b1;
			if (cmd.tupd && !flood && new_q) trk_valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= trk_mem[rd_addr];
		if (cmd.tupd && !flood) trk_mem[idx_q] <= wrec;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) in_q <= in_data;
		if (cmd.ld_out) out_q <= res_q;
		if (cmd.chk) begin
			isq_q   <= q;
			cls_q   <= cls;
			cnt_q   <= '0;
			cmp_v_q <= 1'b0;
			idx_q   <= any_hit ? hit_idx : free_idx;
			new_q   <= !any_hit;
			if (blk_hit) res_q <= '{1'b0, gqff_pkg::VERDICT_BLOCKED, gqff_pkg::CLASS_OTHER};
			else if (!is_game_port(in_q.udp_port))
				res_q <= '{1'b1, gqff_pkg::VERDICT_PASS, gqff_pkg::CLASS_OTHER};
			else res_q <= '{1'b1, gqff_pkg::VERDICT_PASS, cls};
		end
		if (cmd.tscan) begin
			cmp_v_q <= (cnt_q != (TIW + 1)'(TS));
			cmp_i_q <= cnt_q[TIW-1:0];
			if (cnt_q != (TIW + 1)'(TS)) cnt_q <= cnt_q + 1'b1;
			if (cmp_v_q && tbetter) begin
				best_q <= tage;
				idx_q  <= cmp_i_q;
			end
		end
		if (cmd.tupd) begin
			bcnt_q <= '0;
			if (!flood) begin
				res_q <= '{1'b1, gqff_pkg::VERDICT_PASS, cls_q};
				if (new_q) begin
					trk_addr_q[idx_q] <= in_q.src_addr;
					trk_port_q[idx_q] <= in_q.udp_port;
				end
			end else begin
				res_q <= '{1'b0, isq_q ? gqff_pkg::VERDICT_QFLOOD : gqff_pkg::VERDICT_CFLOOD,
					cls_q};
				if (auto_en_q && !blk_full) begin
					blk_addr_q[blk_free]  <= in_q.src_addr;
					blk_start_q[blk_free] <= in_q.now_seconds;
					blk_dur_q[blk_free]   <= block_sec_q;
				end
			end
		end
		if (cmd.bscan) begin
			bcnt_q <= bcnt_q + 1'b1;
			if (bbetter) begin
				best_q <= bage;
				bidx_q <= bcnt_q;
			end
			if (st.bscan_last) begin
				blk_addr_q[bpick]  <= in_q.src_addr;
				blk_start_q[bpick] <= in_q.now_seconds;
				blk_dur_q[bpick]   <= block_sec_q;
			end
		end
	end

	a_tag_unique: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chk |-> $onehot0(trk_hit))
		else $error("duplicate tracker tag");
	a_new_no_flood: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tupd && new_q |-> !flood)
		else $error("fresh tracker flagged as flood");
	a_bscan_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bscan |-> blk_full)
		else $error("block eviction with a free slot");

endmodule

### hdl/game_query_flood_filter.sv
// Top level of the game query flood filter.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready/in_data carries one packet summary word;
//   output channel out_valid/out_ready/out_data carries one verdict word per
//   input word, in order. cfg_we/cfg_index/cfg_data write a register;
//   write only while no word is in flight.
// Sequence:
//   A word passes accept, table check, tracker update and result load when
//   its tracker is found or a free tracker slot exists. With the tracker
//   table full on a miss, the oldest slot is found by a scan of the tracker
//   memory, one entry a cycle. A flood that blocks its source into a full
//   block table adds a scan of that table. The next word is taken once the
//   result is loaded.
// Reset:
//   Clears all tracker and block entries and loads default registers.
// Stall:
//   The result waits in the output register; the block takes and works
//   the next word meanwhile and holds its result until the register frees.
module game_query_flood_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  gqff_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output gqff_pkg::out_word_t             out_data,
	input  logic                            cfg_we,
	input  logic [gqff_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gqff_pkg::CFG_DATA_W-1:0] cfg_data
);

	gqff_pkg::cmd_t  cmd;
	gqff_pkg::stat_t st;

	gqff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	gqff_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

### tb/game_query_flood_filter_test.sv
// Testbench of the game query flood filter: directed and random packet words against a predictor.
`timescale 1ns / 1ps
module game_query_flood_filter_test;

	localparam int TSLOTS = gqff_pkg::TRACK_SLOTS;
	localparam int BSLOTS = gqff_pkg::BLOCK_SLOTS;
	localparam int DRAIN_CYC = TSLOTS + BSLOTS + 8;
	localparam int HOLD_CYC = 300;
	localparam int QUIET_LIMIT = 20 * (TSLOTS + BSLOTS) + 4 * HOLD_CYC;
	localparam logic [gqff_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int KIND_QUERY = 0;
	localparam int KIND_CONN = 1;
	localparam int KIND_RCON = 2;
	localparam int KIND_LOOSE = 3;
	localparam int KIND_SHORT = 4;
	localparam int KIND_NOISE = 5;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	gqff_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	gqff_pkg::out_word_t out_data;
	logic cfg_we;
	logic [gqff_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gqff_pkg::CFG_DATA_W-1:0] cfg_data;

	game_query_flood_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bit cfg_qen, cfg_cen, cfg_ab;
	bit [31:0] cfg_bsec, cfg_qsec, cfg_qmin, cfg_csec;

	bit trk_v[TSLOTS];
	bit [31:0] trk_a[TSLOTS];
	bit [15:0] trk_p[TSLOTS];
	bit [31:0] trk_ws[TSLOTS];
	bit [31:0] trk_q[TSLOTS];
	bit [31:0] trk_c[TSLOTS];
	bit [31:0] trk_seen[TSLOTS];
	bit blk_v[BSLOTS];
	bit [31:0] blk_a[BSLOTS];
	bit [31:0] blk_start[BSLOTS];
	bit [31:0] blk_dur[BSLOTS];

	gqff_pkg::out_word_t verdict_q[$];
	bit failed;
	bit idle_on;
	bit hold_req;
	int hold_cnt;
	int quiet;
	bit [31:0] clk_now;
	bit [31:0] src_pool[96];
	bit [15:0] game_ports[28];
	bit [7:0] query_ops[5] = '{8'h49, 8'h54, 8'h55, 8'h56, 8'h41};

	function automatic bit game_port(bit [15:0] p);
		return (p >= 16'd27010 && p <= 16'd27030) ||
			(p inside {16'd3478, 16'd4379, 16'd4380, 16'd27005, 16'd27006, 16'd27036, 16'd27037});
	endfunction

	function automatic void block_add(bit [31:0] a, bit [31:0] now);
		int pick;
		bit [31:0] best, age;
		pick = -1;
		best = 0;
		for (int i = 0; i < BSLOTS; i++)
			if (pick < 0 && !blk_v[i]) pick = i;
		if (pick < 0) begin
			for (int i = 0; i < BSLOTS; i++) begin
				age = now - blk_start[i];
				if (i == 0 || age > best) begin
					best = age;
					pick = i;
				end
			end
		end
		blk_v[pick] = 1'b1;
		blk_a[pick] = a;
		blk_start[pick] = now;
		blk_dur[pick] = cfg_bsec;
	endfunction

	function automatic int tracker_claim(bit [31:0] a, bit [15:0] p, bit [31:0] now);
		int pick;
		bit [31:0] best, age;
		for (int i = 0; i < TSLOTS; i++)
			if (trk_v[i] && trk_a[i] == a && trk_p[i] == p) return i;
		pick = -1;
		best = 0;
		for (int i = 0; i < TSLOTS; i++)
			if (pick < 0 && !trk_v[i]) pick = i;
		if (pick < 0) begin
			for (int i = 0; i < TSLOTS; i++) begin
				age = now - trk_seen[i];
				if (i == 0 || age > best) begin
					best = age;
					pick = i;
				end
			end
		end
		trk_v[pick] = 1'b1;
		trk_a[pick] = a;
		trk_p[pick] = p;
		trk_ws[pick] = now;
		trk_q[pick] = 32'd0;
		trk_c[pick] = 32'd0;
		trk_seen[pick] = now;
		return pick;
	endfunction

	function automatic void tracker_bump(int t, bit count_query, bit [31:0] now);
		if (now - trk_ws[t] >= 32'd60) begin
			trk_q[t] = 32'd0;
			trk_c[t] = 32'd0;
			trk_ws[t] = now;
		end
		if (count_query) begin
			if (trk_q[t] != '1) trk_q[t]++;
		end else begin
			if (trk_c[t] != '1) trk_c[t]++;
		end
		trk_seen[t] = now;
	endfunction

	function automatic gqff_pkg::out_word_t predict_verdict(gqff_pkg::in_word_t w);
		bit [31:0] now, age;
		bit pre, q, c, rc, flood;
		logic [1:0] cls;
		int t;
		now = w.now_seconds;
		for (int i = 0; i < BSLOTS; i++)
			if (blk_v[i] && (now - blk_start[i]) > blk_dur[i]) blk_v[i] = 1'b0;
		for (int i = 0; i < BSLOTS; i++)
			if (blk_v[i] && blk_a[i] == w.src_addr)
				return '{1'b0, gqff_pkg::VERDICT_BLOCKED, gqff_pkg::CLASS_OTHER};
		if (!game_port(w.udp_port))
			return '{1'b1, gqff_pkg::VERDICT_PASS, gqff_pkg::CLASS_OTHER};
		pre = w.payload_len >= 16'd5 && w.hdr_byte0 == 8'hFF && w.hdr_byte1 == 8'hFF &&
			w.hdr_byte2 == 8'hFF && w.hdr_byte3 == 8'hFF;
		q = pre && (w.hdr_byte4 inside {8'h49, 8'h54, 8'h55, 8'h56, 8'h41});
		c = pre && (w.hdr_byte4 == 8'h09 || w.hdr_byte4 == 8'h0C ||
			(w.payload_len >= 16'd6 && w.hdr_byte4 == 8'h01 && w.hdr_byte5 == 8'h00));
		rc = pre && w.payload_len >= 16'd12 && w.hdr_byte4 == 8'h63;
		if (!q && !c && !rc && w.payload_len > 16'd0 && w.hdr_byte0 == 8'hFF) q = 1'b1;
		cls = q ? gqff_pkg::CLASS_QUERY : c ? gqff_pkg::CLASS_CONN :
			rc ? gqff_pkg::CLASS_RCON : gqff_pkg::CLASS_OTHER;
		if (q && cfg_qen) begin
			t = tracker_claim(w.src_addr, w.udp_port, now);
			age = now - trk_ws[t];
			flood = 1'b0;
			if (age >= 32'd1) begin
				if (trk_q[t] > cfg_qsec) flood = 1'b1;
				else begin
					trk_q[t] = 32'd0;
					trk_ws[t] = now;
				end
			end
			if (!flood && age >= 32'd60 && trk_q[t] > cfg_qmin) flood = 1'b1;
			if (flood) begin
				if (cfg_ab) block_add(w.src_addr, now);
				return '{1'b0, gqff_pkg::VERDICT_QFLOOD, cls};
			end
			tracker_bump(t, 1'b1, now);
		end
		if (c && cfg_cen) begin
			t = tracker_claim(w.src_addr, w.udp_port, now);
			age = now - trk_ws[t];
			if (age >= 32'd1) begin
				if (trk_c[t] > cfg_csec) begin
					if (cfg_ab) block_add(w.src_addr, now);
					return '{1'b0, gqff_pkg::VERDICT_CFLOOD, cls};
				end
				trk_c[t] = 32'd0;
				trk_ws[t] = now;
			end
			tracker_bump(t, 1'b0, now);
		end
		return '{1'b1, gqff_pkg::VERDICT_PASS, cls};
	endfunction

	function automatic gqff_pkg::in_word_t make_packet(bit [31:0] src, bit [15:0] port,
			int kind, bit [31:0] now);
		gqff_pkg::in_word_t w;
		int pick;
		w = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w.src_addr = src;
		w.udp_port = port;
		w.now_seconds = now;
		if (kind != KIND_NOISE) begin
			w.hdr_byte0 = 8'hFF;
			w.hdr_byte1 = 8'hFF;
			w.hdr_byte2 = 8'hFF;
			w.hdr_byte3 = 8'hFF;
			w.payload_len = 16'($urandom_range(12, 1400));
		end
		case (kind)
			KIND_QUERY: w.hdr_byte4 = query_ops[$urandom_range(0, 4)];
			KIND_CONN: begin
				pick = $urandom_range(0, 2);
				w.hdr_byte4 = pick == 0 ? 8'h09 : pick == 1 ? 8'h0C : 8'h01;
				if (pick == 2) w.hdr_byte5 = 8'h00;
			end
			KIND_RCON: w.hdr_byte4 = 8'h63;
			KIND_LOOSE: w.hdr_byte1 = 8'($urandom_range(0, 254));
			KIND_SHORT: begin
				w.payload_len = 16'($urandom_range(0, 4));
				w.hdr_byte4 = query_ops[$urandom_range(0, 4)];
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_word(gqff_pkg::in_word_t w);
		if (idle_on && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		verdict_q = {verdict_q, predict_verdict(w)};
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [gqff_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gqff_pkg::REG_QUERY_PROTECT_EN: cfg_qen = val[0];
			gqff_pkg::REG_CONN_PROTECT_EN: cfg_cen = val[0];
			gqff_pkg::REG_AUTO_BLOCK_EN: cfg_ab = val[0];
			gqff_pkg::REG_BLOCK_SECONDS: cfg_bsec = val;
			gqff_pkg::REG_MAX_QUERIES_SEC: cfg_qsec = val;
			gqff_pkg::REG_MAX_QUERIES_MIN: cfg_qmin = val;
			gqff_pkg::REG_MAX_CONNS_SEC: cfg_csec = val;
			default: ;
		endcase
	endtask

	task automatic write_all(bit qen, bit cen, bit ab, bit [31:0] bsec, bit [31:0] qsec,
			bit [31:0] qmin, bit [31:0] csec);
		write_reg(gqff_pkg::REG_QUERY_PROTECT_EN, {31'h7FFF_FFFF, qen});
		write_reg(gqff_pkg::REG_CONN_PROTECT_EN, {31'h0, cen});
		write_reg(gqff_pkg::REG_AUTO_BLOCK_EN, {31'h5555_5555, ab});
		write_reg(gqff_pkg::REG_BLOCK_SECONDS, bsec);
		write_reg(gqff_pkg::REG_MAX_QUERIES_SEC, qsec);
		write_reg(gqff_pkg::REG_MAX_QUERIES_MIN, qmin);
		write_reg(gqff_pkg::REG_MAX_CONNS_SEC, csec);
	endtask

	function automatic bit [15:0] pick_port();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return game_ports[$urandom_range(0, 2)];
		if (r < 85) return game_ports[$urandom_range(0, 27)];
		return 16'($urandom);
	endfunction

	task automatic send_random(int n_src);
		int r, kind;
		r = $urandom_range(0, 99);
		if (r < 68) ;
		else if (r < 95) clk_now += 32'd1;
		else if (r < 99) clk_now += $urandom_range(60, 400);
		else clk_now += $urandom;
		r = $urandom_range(0, 99);
		kind = r < 45 ? KIND_QUERY : r < 70 ? KIND_CONN : r < 75 ? KIND_RCON :
			r < 80 ? KIND_LOOSE : r < 85 ? KIND_SHORT : KIND_NOISE;
		send_word(make_packet(src_pool[$urandom_range(0, n_src - 1)], pick_port(), kind,
			clk_now));
	endtask

	task automatic test_directed();
		gqff_pkg::in_word_t w;
		clk_now = 32'd0;
		send_word(make_packet(32'h0, 16'd27015, KIND_QUERY, 32'd0));
		send_word(make_packet(32'h0, 16'd27010, KIND_CONN, 32'd0));
		send_word(make_packet(32'hFFFF_FFFF, 16'd27030, KIND_RCON, 32'hFFFF_FFFF));
		send_word(make_packet(32'h1, 16'd3478, KIND_LOOSE, 32'd1));
		send_word(make_packet(32'h2, 16'd27037, KIND_SHORT, 32'd1));
		send_word(make_packet(32'h3, 16'd27009, KIND_QUERY, 32'd1));
		send_word(make_packet(32'h3, 16'd27031, KIND_QUERY, 32'd1));
		send_word(make_packet(32'h3, 16'd0, KIND_CONN, 32'd1));
		send_word(make_packet(32'h3, 16'hFFFF, KIND_CONN, 32'd1));
		w = make_packet(32'h4, 16'd4379, KIND_CONN, 32'd2);
		w.hdr_byte4 = 8'h01;
		w.hdr_byte5 = 8'h00;
		w.payload_len = 16'd6;
		send_word(w);
		w.payload_len = 16'd5;
		send_word(w);
		w = make_packet(32'h5, 16'd4380, KIND_RCON, 32'd2);
		w.payload_len = 16'd12;
		send_word(w);
		w.payload_len = 16'd11;
		send_word(w);
		w.payload_len = 16'd0;
		send_word(w);
		w.payload_len = 16'hFFFF;
		w.hdr_byte0 = 8'h00;
		send_word(w);
		send_word(make_packet(32'h6, 16'd27005, KIND_NOISE, 32'd3));
		send_word(make_packet(32'h6, 16'd27006, KIND_QUERY, 32'h8000_0000));
		send_word(make_packet(32'h6, 16'd27036, KIND_CONN, 32'h7FFF_FFFF));
		wait_drained();
	endtask

	task automatic test_block_table();
		write_all(1'b1, 1'b1, 1'b1, 32'd5, 32'd0, 32'd0, 32'd0);
		clk_now = 32'd1000;
		for (int s = 0; s < 20; s++) begin
			send_word(make_packet(src_pool[s], 16'd27015, s[0] ? KIND_CONN : KIND_QUERY,
				clk_now));
			send_word(make_packet(src_pool[s], 16'd27015, s[0] ? KIND_CONN : KIND_QUERY,
				clk_now + 32'd1));
		end
		clk_now += 32'd3;
		for (int s = 0; s < 20; s++)
			send_word(make_packet(src_pool[s], 16'd27015, KIND_QUERY, clk_now));
		clk_now += 32'd6;
		for (int s = 0; s < 20; s++)
			send_word(make_packet(src_pool[s], 16'd80, KIND_QUERY, clk_now));
		wait_drained();
	endtask

	task automatic test_tracker_evict();
		write_all(1'b1, 1'b1, 1'b0, 32'd300, 32'd100, 32'd1000, 32'd20);
		clk_now = 32'd5000;
		for (int s = 0; s < 90; s++) begin
			if (s % 10 == 0) clk_now += 32'd1;
			send_word(make_packet(src_pool[s], 16'd27020, s[1] ? KIND_CONN : KIND_QUERY,
				clk_now));
		end
		wait_drained();
	endtask

	task automatic test_config_sweep();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: write_all(1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
				1: write_all(1'b1, 1'b1, 1'b1, '1, '1, '1, '1);
				2: write_all(1'b1, 1'b0, 1'b1, 32'd0, 32'd1, 32'd0, 32'd2);
				default: write_all(1'b0, 1'b1, 1'b1, 32'd2, 32'd0, 32'd5, 32'd1);
			endcase
			for (int n = 0; n < 50; n++) send_random(8);
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_req = 1'b1;
		for (int n = 0; n < 12; n++) send_random(8);
		wait_drained();
		idle_on = 1'b1;
	endtask

	task automatic test_random();
		write_all(1'b1, 1'b1, 1'b1, 32'd20, 32'd3, 32'd1000, 32'd2);
		for (int n = 0; n < 420; n++) begin
			idle_on = !(n >= 150 && n < 300);
			if (n == 330)
				write_all(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)), 32'd100,
					32'd5, 32'd10, 32'd4);
			send_random(n < 330 ? 10 : 96);
		end
		idle_on = 1'b1;
		wait_drained();
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected word accept=%0d verdict=%0d class=%0d", $time,
					out_data.accept, out_data.verdict, out_data.pkt_class);
				failed = 1'b1;
			end else begin
				if (out_data.accept !== verdict_q[0].accept) begin
					$display("%0t: accept expected %0d actual %0d", $time,
						verdict_q[0].accept, out_data.accept);
					failed = 1'b1;
				end
				if (out_data.verdict !== verdict_q[0].verdict) begin
					$display("%0t: verdict expected %0d actual %0d", $time,
						verdict_q[0].verdict, out_data.verdict);
					failed = 1'b1;
				end
				if (out_data.pkt_class !== verdict_q[0].pkt_class) begin
					$display("%0t: pkt_class expected %0d actual %0d", $time,
						verdict_q[0].pkt_class, out_data.pkt_class);
					failed = 1'b1;
				end
				void'(verdict_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req && hold_cnt < HOLD_CYC) begin
			hold_cnt <= hold_cnt + 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(0, 99) < 13);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(!in_valid && verdict_q.size() == 0))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		cfg_qen = 1'b1;
		cfg_cen = 1'b1;
		cfg_ab = 1'b1;
		cfg_bsec = 32'd300;
		cfg_qsec = 32'd100;
		cfg_qmin = 32'd1000;
		cfg_csec = 32'd20;
		foreach (src_pool[i]) src_pool[i] = $urandom;
		src_pool[0] = 32'h0;
		src_pool[1] = 32'hFFFF_FFFF;
		for (int i = 0; i < 21; i++) game_ports[i + 7] = 16'(27010 + i);
		game_ports[0] = 16'd27015;
		game_ports[1] = 16'd27016;
		game_ports[2] = 16'd3478;
		game_ports[3] = 16'd4379;
		game_ports[4] = 16'd4380;
		game_ports[5] = 16'd27005;
		game_ports[6] = 16'd27036;
		game_ports[27] = 16'd27037;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_block_table();
		test_tracker_evict();
		test_config_sweep();
		test_backpressure();
		test_random();
		if (!failed && verdict_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
